// File: rtl/core/wsg_pkg.sv
// Shared types, codes and sine table math for the waveform sample generator.
`timescale 1ns / 1ps
`default_nettype none

package wsg_pkg;

  // Fixed field widths
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned AMP_W   = 16;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned LFSR_W  = 31;
  localparam int unsigned NOISE_W = 15;
  localparam int unsigned SINE_W  = 16;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned REGI_W  = 3;

  // Sine constants: cycles per period, DC offset, pi/2 in Q30
  localparam int unsigned     SINE_CYCLES = 99;
  localparam int unsigned     SINE_OFFSET = 2047;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    WAVE_RECT  = 3'd0,
    WAVE_SINE  = 3'd1,
    WAVE_SAW   = 3'd2,
    WAVE_TRI   = 3'd3,
    WAVE_NOISE = 3'd4
  } wave_e;

  typedef enum logic [REGI_W-1:0] {
    REG_WAVE_KIND  = 3'd0,
    REG_AMPLITUDE  = 3'd1,
    REG_DUTY       = 3'd2,
    REG_RELOAD     = 3'd3,
    REG_NOISE_SEED = 3'd4,
    REG_RUN_ENABLE = 3'd5
  } reg_index_e;

  typedef struct packed {
    logic [2:0]        wave_kind;
    logic [AMP_W-1:0]  amplitude;
    logic [DUTY_W-1:0] duty_entries;
    logic [TICK_W-1:0] reload;
    logic [LFSR_W-1:0] noise_seed;
    logic              run_enable;
  } cfg_t;

  // One sample job handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0]         index;
    logic signed [SINE_W-1:0] sine;
    logic [NOISE_W-1:0]       noise;
  } job_t;

  // Magnitude of sin(x) in Q1.15, x in Q30 within the first quadrant
  function automatic logic [15:0] sin_q15_mag(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] q;
    x2   = (x * x) >> 30;
    s    = x;
    term = ((x * x2) >> 30) / 64'd6;
    s    = s - term;
    term = ((term * x2) >> 30) / 64'd20;
    s    = s + term;
    term = ((term * x2) >> 30) / 64'd42;
    s    = s - term;
    term = ((term * x2) >> 30) / 64'd72;
    s    = s + term;
    term = ((term * x2) >> 30) / 64'd110;
    s    = s - term;
    q    = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[15:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/waveform_sample_generator.sv
// Top level of the waveform sample generator: config registers, front, queue, back.
//
//   channel  direction  handshake                 word
//   in       input      in_valid_i / in_ready_o   restart_i
//   out      output     out_valid_o / out_ready_i sample_value_o, sample_index_o
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// Ticks that make no sample stream at one per cycle while the queue is not full.
// A sample tick issues a job to a two-word queue; the back end passes rectangle,
// sine, sawtooth, triangle and zero-amplitude noise jobs through its idle and finish
// states, and other noise jobs through a 15-step remainder as well.
// in_ready_o drops only while the queue is full; out_valid_o holds until out_ready_i.
// Reset clears counters, queue and output; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module waveform_sample_generator #(
  parameter int unsigned SAMPLES_PER_PERIOD = 100
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wsg_pkg::REGI_W-1:0]    cfg_index_i,
  input  wire logic [wsg_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          restart_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [wsg_pkg::VAL_W-1:0]          sample_value_o,
  output logic [wsg_pkg::IDX_W-1:0]          sample_index_o
);
  import wsg_pkg::*;

  cfg_t cfg_q;
  logic queue_full;
  logic push;
  job_t push_job;
  logic job_valid;
  logic job_pop;
  job_t job;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_kind    <= WAVE_RECT;
      cfg_q.amplitude    <= '0;
      cfg_q.duty_entries <= DUTY_W'(50);
      cfg_q.reload       <= '1;
      cfg_q.noise_seed   <= LFSR_W'(1);
      cfg_q.run_enable   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WAVE_KIND:  cfg_q.wave_kind    <= cfg_data_i[2:0];
        REG_AMPLITUDE:  cfg_q.amplitude    <= cfg_data_i[AMP_W-1:0];
        REG_DUTY:       cfg_q.duty_entries <= cfg_data_i[DUTY_W-1:0];
        REG_RELOAD:     cfg_q.reload       <= cfg_data_i[TICK_W-1:0];
        REG_NOISE_SEED: cfg_q.noise_seed   <= cfg_data_i[LFSR_W-1:0];
        REG_RUN_ENABLE: cfg_q.run_enable   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  wsg_front #(
    .SAMPLES_PER_PERIOD(SAMPLES_PER_PERIOD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  wsg_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (queue_full),
    .valid_o    (job_valid),
    .pop_i      (job_pop),
    .pop_job_o  (job)
  );

  wsg_back #(
    .SAMPLES_PER_PERIOD(SAMPLES_PER_PERIOD)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_pop_o      (job_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_value_o (sample_value_o),
    .sample_index_o (sample_index_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/wsg_front.sv
// Front end: tick counter, phase index, sine phase, noise LFSR and job issue.
`timescale 1ns / 1ps
`default_nettype none

module wsg_front #(
  parameter int unsigned SAMPLES_PER_PERIOD = 100
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire wsg_pkg::cfg_t                cfg_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         restart_i,
  input  wire logic                         queue_full_i,
  output logic                              push_o,
  output wsg_pkg::job_t                     job_o
);
  import wsg_pkg::*;

  localparam int unsigned N  = SAMPLES_PER_PERIOD;
  localparam int unsigned KW = $clog2(N);
  localparam logic [KW:0] SINE_STEP = (KW+1)'(SINE_CYCLES % N);
  localparam logic [KW:0] N_K       = (KW+1)'(N);
  localparam logic [IDX_W:0] N_I    = (IDX_W+1)'(N);

  logic signed [SINE_W-1:0] sine_tab [N];

  // Build the sine table at elaboration, one entry per phase step
  for (genvar g = 0; g < N; g++) begin : g_sine
    localparam longint unsigned T0 = 64'(4 * g);
    localparam bit              NEG = (T0 >= 64'(2 * N));
    localparam longint unsigned T1 = NEG ? (T0 - 64'(2 * N)) : T0;
    localparam longint unsigned T2 = (T1 > 64'(N)) ? (64'(2 * N) - T1) : T1;
    localparam longint unsigned XA = (T2 * HALF_PI_Q30) / 64'(N);
    localparam logic [15:0]     MAG = sin_q15_mag(XA);
    localparam logic signed [SINE_W-1:0] VAL = NEG ? -$signed(MAG) : $signed(MAG);
    assign sine_tab[g] = VAL;
  end

  logic [TICK_W-1:0] tick_q, tick_d;
  logic [IDX_W-1:0]  phase_q, phase_d;
  logic [KW-1:0]     k_q, k_d;
  logic [LFSR_W-1:0] lfsr_q, lfsr_d;

  logic [TICK_W-1:0] tc;
  logic [IDX_W-1:0]  ph;
  logic [KW-1:0]     kc;
  logic [LFSR_W-1:0] lfsr_base;
  logic [KW:0]       k_sum;
  logic              accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Apply restart, count ticks, and issue a job on reload
  always_comb begin
    tc        = restart_i ? '0 : tick_q;
    ph        = restart_i ? '0 : phase_q;
    kc        = restart_i ? '0 : k_q;
    tick_d    = tick_q;
    phase_d   = phase_q;
    k_d       = k_q;
    lfsr_d    = lfsr_q;
    push_o    = 1'b0;
    k_sum     = {1'b0, kc} + SINE_STEP;
    lfsr_base = lfsr_q;
    if (ph == '0) begin
      lfsr_base = (cfg_i.noise_seed != '0) ? cfg_i.noise_seed : LFSR_W'(1);
    end
    if (accept) begin
      tick_d  = tc;
      phase_d = ph;
      k_d     = kc;
      if (cfg_i.run_enable) begin
        if (tc < cfg_i.reload) begin
          tick_d = tc + TICK_W'(1);
        end else begin
          tick_d = '0;
          push_o = 1'b1;
          lfsr_d = {lfsr_base[LFSR_W-2:0], lfsr_base[30] ^ lfsr_base[27]};
          if (({1'b0, ph} + (IDX_W+1)'(1)) >= N_I) begin
            phase_d = '0;
            k_d     = '0;
          end else begin
            phase_d = ph + IDX_W'(1);
            k_d     = (k_sum >= N_K) ? KW'(k_sum - N_K) : k_sum[KW-1:0];
          end
        end
      end
    end
    job_o.index = ph;
    job_o.sine  = sine_tab[kc];
    job_o.noise = lfsr_d[LFSR_W-1:LFSR_W-NOISE_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      phase_q <= '0;
      k_q     <= '0;
      lfsr_q  <= LFSR_W'(1);
    end else begin
      tick_q  <= tick_d;
      phase_q <= phase_d;
      k_q     <= k_d;
      lfsr_q  <= lfsr_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, phase_q} < N_I)
    else $error("phase index out of range");

  a_sine_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, k_q} < N_K)
    else $error("sine phase out of range");

  a_phase_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == '0) |-> (k_q == '0))
    else $error("sine phase not zero at period start");
`endif

endmodule

`default_nettype wire

// File: rtl/core/wsg_fifo.sv
// Short job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module wsg_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire wsg_pkg::job_t push_job_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output wsg_pkg::job_t      pop_job_o
);
  import wsg_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;
  assign pop_job_o = mem_q[rd_ptr_q];

  // Store words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_ptr_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with empty count");

  a_push_dropped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

// File: rtl/core/wsg_back.sv
// Back end: wave arithmetic, noise remainder unit and output register.
`timescale 1ns / 1ps
`default_nettype none

module wsg_back #(
  parameter int unsigned SAMPLES_PER_PERIOD = 100
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire wsg_pkg::cfg_t                cfg_i,
  input  wire logic                         job_valid_i,
  input  wire wsg_pkg::job_t                job_i,
  output logic                              job_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [wsg_pkg::VAL_W-1:0]         sample_value_o,
  output logic [wsg_pkg::IDX_W-1:0]         sample_index_o
);
  import wsg_pkg::*;

  localparam int unsigned N = SAMPLES_PER_PERIOD;
  localparam logic [IDX_W:0] N_I  = (IDX_W+1)'(N);
  localparam logic [IDX_W-1:0] HALF = IDX_W'(N / 2);
  localparam int unsigned OP_W   = SINE_W + 1;
  localparam int unsigned PROD_W = 2 * OP_W;
  localparam int unsigned NUM_W  = PROD_W + 1;
  localparam logic signed [NUM_W-1:0] SINE_BIAS = NUM_W'(SINE_OFFSET * 32768);
  localparam logic [3:0] DIV_LAST = 4'(NOISE_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e                    state_q;
  logic [IDX_W-1:0]          index_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [AMP_W-1:0]          rem_q;
  logic [NOISE_W-1:0]        dvd_q;
  logic [3:0]                cnt_q;
  logic                      out_valid_q;
  logic [VAL_W-1:0]          out_value_q;
  logic [IDX_W-1:0]          out_index_q;

  logic [IDX_W-1:0]          tri_dist;
  logic signed [OP_W-1:0]    op;
  logic signed [PROD_W-1:0]  prod;
  logic [AMP_W:0]            rem_shift;
  logic [AMP_W-1:0]          rem_next;
  logic [IDX_W:0]            duty_lim;
  logic signed [NUM_W-1:0]   num;
  logic [VAL_W-1:0]          value;
  logic                      out_free;

  assign out_free       = !out_valid_q || out_ready_i;
  assign job_pop_o      = (state_q == ST_IDLE) && job_valid_i;
  assign out_valid_o    = out_valid_q;
  assign sample_value_o = out_value_q;
  assign sample_index_o = out_index_q;

  // Pick the multiplier operand for the job being popped
  always_comb begin
    tri_dist = (job_i.index > HALF) ? (job_i.index - HALF) : (HALF - job_i.index);
    case (cfg_i.wave_kind)
      WAVE_SINE: op = OP_W'(job_i.sine);
      WAVE_SAW:  op = $signed({{(OP_W-IDX_W){1'b0}}, job_i.index});
      WAVE_TRI:  op = $signed({{(OP_W-IDX_W){1'b0}}, tri_dist});
      default:   op = '0;
    endcase
    prod = op * $signed({1'b0, cfg_i.amplitude});
  end

  // One restoring step of the noise remainder
  always_comb begin
    rem_shift = {rem_q, dvd_q[NOISE_W-1]};
    if (rem_shift >= {1'b0, cfg_i.amplitude}) begin
      rem_next = AMP_W'(rem_shift - {1'b0, cfg_i.amplitude});
    end else begin
      rem_next = rem_shift[AMP_W-1:0];
    end
  end

  // Form the final sample from the registered product or remainder
  always_comb begin
    duty_lim = ({1'b0, cfg_i.duty_entries} > N_I) ? N_I : {1'b0, cfg_i.duty_entries};
    num      = SINE_BIAS + NUM_W'(prod_q);
    case (cfg_i.wave_kind)
      WAVE_RECT: value = ({1'b0, index_q} < duty_lim) ? cfg_i.amplitude : '0;
      WAVE_SINE: begin
        if (num[NUM_W-1]) begin
          value = '0;
        end else if (num[NUM_W-1:15] > (NUM_W-15)'(16'hFFFF)) begin
          value = '1;
        end else begin
          value = num[15+VAL_W-1:15];
        end
      end
      WAVE_SAW:   value = prod_q[VAL_W-1:0];
      WAVE_TRI:   value = prod_q[VAL_W-1:0];
      WAVE_NOISE: value = rem_q;
      default:    value = '0;
    endcase
  end

  // Sequence each job and hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      index_q     <= '0;
      prod_q      <= '0;
      rem_q       <= '0;
      dvd_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_index_q <= '0;
    end else begin
      // Load a finished sample, or drop the word that was taken
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            index_q <= job_i.index;
            prod_q  <= prod;
            rem_q   <= '0;
            dvd_q   <= job_i.noise;
            cnt_q   <= DIV_LAST;
            if ((cfg_i.wave_kind == WAVE_NOISE) && (cfg_i.amplitude != '0)) begin
              state_q <= ST_DIV;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_DIV: begin
          rem_q <= rem_next;
          dvd_q <= {dvd_q[NOISE_W-2:0], 1'b0};
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == '0) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_value_q <= value;
            out_index_q <= index_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_below_modulus : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < cfg_i.amplitude))
    else $error("noise remainder not below amplitude");

  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, out_index_q} < N_I))
    else $error("sample index out of range");

  a_finish_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && out_free) |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished sample not loaded into output");

  a_div_only_noise : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cfg_i.wave_kind == WAVE_NOISE))
    else $error("remainder unit busy for a non-noise wave");
`endif

endmodule

`default_nettype wire
